FILE: src/qenc_pkg.sv
// shared types, function codes and defaults for the quadrature encoder block
package qenc_pkg;

	// default bank size
	localparam int QENC_ENCODERS = 2;

	// debounce time after reset, in milliseconds
	localparam logic [15:0] QENC_DEBOUNCE_RST = 16'd50;

	// function codes of an input item
	localparam logic [2:0] FN_SAMPLE     = 3'd0;
	localparam logic [2:0] FN_INIT       = 3'd1;
	localparam logic [2:0] FN_DELTA_CLR  = 3'd2;
	localparam logic [2:0] FN_POSITION   = 3'd3;
	localparam logic [2:0] FN_ZERO_POS   = 3'd4;
	localparam logic [2:0] FN_EDGE_CLR   = 3'd5;
	localparam logic [2:0] FN_PRESSED    = 3'd6;
	localparam logic [2:0] FN_COUNT_CLR  = 3'd7;

	// last step direction codes, two's complement
	localparam logic [1:0] DIR_UP   = 2'b01;
	localparam logic [1:0] DIR_DOWN = 2'b11;
	localparam logic [1:0] DIR_NONE = 2'b00;

	typedef struct packed {
		logic [2:0]  func;
		logic [1:0]  encoder_id;
		logic        phase_a;
		logic        phase_b;
		logic        button_level;
		logic [31:0] now_ms;
	} qenc_in_t;

	typedef struct packed {
		logic signed [31:0] read_value;
		logic               id_valid;
	} qenc_out_t;

	// one memory word per encoder
	typedef struct packed {
		logic [31:0] position_count;
		logic [1:0]  last_direction;
		logic        prev_phase_a;
		logic        prev_phase_b;
		logic        prev_button;
		logic        pressed_flag;
		logic        press_edge;
		logic [7:0]  press_total;
		logic [31:0] change_time;
	} qenc_state_t;

endpackage

FILE: src/quadrature_encoder_with_button_core.sv
// top level: quadrature encoder bank with debounced buttons
// a bank of ENCODERS rotary encoders whose state sits in one memory word per
// encoder; every item names an encoder and a function (sample, init, reads,
// read-and-clear, zero position) and yields exactly one result item, with
// id_valid low and a zero value when the encoder number is out of range. the
// block takes one item per clock unless stalled: an accepted item reads its
// encoder's word in the accept cycle, the next cycle computes the new word and
// the result, and the word is written back as the result enters the output
// register. back-to-back items on the same encoder see each other through a
// bypass on the memory read port, so there is no bubble. the state memory needs
// no clearing pass after reset: per-entry valid bits make an unwritten encoder
// read as all zero. debounce_ms resets to 50 and is written through cfg_we /
// cfg_wdata; the user must do so only while the block is idle, unenforced by it.
module quadrature_encoder_with_button_core
	import qenc_pkg::*;
#(
	parameter int ENCODERS = QENC_ENCODERS
) (
	input  logic        clk,
	input  logic        arst_n,
	// configuration write
	input  logic        cfg_we,
	input  logic [15:0] cfg_wdata,
	// input items
	input  logic        in_valid,
	output logic        in_stall,
	input  qenc_in_t    in_item,
	// result items
	output logic        out_valid,
	input  logic        out_stall,
	output qenc_out_t   out_item
);

	// memory address width, at least one bit
	localparam int AW = (ENCODERS > 1) ? $clog2(ENCODERS) : 1;

	logic [15:0] debounce_q;

	// stage 1: item waiting on its memory read
	logic        valid_s1;
	qenc_in_t    item_s1;
	logic        id_ok_s1;
	logic [AW-1:0] addr_s1;

	// output register
	logic        out_valid_q;
	qenc_out_t   out_item_q;

	logic          advance;
	logic          accept;
	logic          id_ok_in;
	logic [AW-1:0] addr_in;
	logic          commit;
	qenc_state_t   cur_state;
	qenc_state_t   nxt_state;
	logic [31:0]   value;

	// the output register frees up when empty or when its item is taken
	assign advance  = !out_valid_q || !out_stall;
	assign in_stall = valid_s1 && !advance;
	assign accept   = in_valid && !in_stall;

	// encoder number check and memory address
	assign id_ok_in = ({30'd0, in_item.encoder_id} < 32'(ENCODERS));
	assign addr_in  = AW'(in_item.encoder_id);

	// write back happens as the result leaves stage 1
	assign commit = valid_s1 && advance && id_ok_s1;

	qenc_state_ram #(
		.ENCODERS(ENCODERS),
		.AW(AW)
	) u_ram (
		.clk(clk),
		.arst_n(arst_n),
		.rd_en(accept && id_ok_in),
		.rd_addr(addr_in),
		.rd_data(cur_state),
		.wr_en(commit),
		.wr_addr(addr_s1),
		.wr_data(nxt_state)
	);

	qenc_update u_update (
		.item(item_s1),
		.cur(cur_state),
		.debounce_ms(debounce_q),
		.nxt(nxt_state),
		.value(value)
	);

	// configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			debounce_q <= QENC_DEBOUNCE_RST;
		end else if (cfg_we) begin
			debounce_q <= cfg_wdata;
		end
	end

	// stage 1 control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	// stage 1 payload, held while stalled
	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1  <= in_item;
			id_ok_s1 <= id_ok_in;
			addr_s1  <= addr_in;
		end
	end

	// output register control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= valid_s1;
		end
	end

	// result payload; out-of-range encoders give zero
	always_ff @(posedge clk) begin
		if (advance && valid_s1) begin
			out_item_q.read_value <= id_ok_s1 ? value : '0;
			out_item_q.id_valid   <= id_ok_s1;
		end
	end

	assign out_valid = out_valid_q;
	assign out_item  = out_item_q;

endmodule

FILE: src/qenc_state_ram.sv
// per-encoder state memory with entry valid bits and write-to-read bypass
module qenc_state_ram
	import qenc_pkg::*;
#(
	parameter int ENCODERS = QENC_ENCODERS,
	parameter int AW = 1
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          rd_en,
	input  logic [AW-1:0] rd_addr,
	output qenc_state_t   rd_data,
	input  logic          wr_en,
	input  logic [AW-1:0] wr_addr,
	input  qenc_state_t   wr_data
);

	qenc_state_t mem [ENCODERS];
	logic [ENCODERS-1:0] vld_q;
	qenc_state_t rd_data_s1;
	logic rd_vld_s1;

	// storage and registered read, write data bypassed on a same-entry collision
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			if (wr_en && (wr_addr == rd_addr)) begin
				rd_data_s1 <= wr_data;
			end else begin
				rd_data_s1 <= mem[rd_addr];
			end
		end
	end

	// entries read as zero until first written
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
			rd_vld_s1 <= 1'b0;
		end else begin
			if (wr_en) begin
				vld_q[wr_addr] <= 1'b1;
			end
			if (rd_en) begin
				rd_vld_s1 <= (wr_en && (wr_addr == rd_addr)) || vld_q[rd_addr];
			end
		end
	end

	assign rd_data = rd_vld_s1 ? rd_data_s1 : '0;

endmodule

FILE: src/qenc_update.sv
// next-state and result logic for one item against one encoder's state
module qenc_update
	import qenc_pkg::*;
(
	input  qenc_in_t    item,
	input  qenc_state_t cur,
	input  logic [15:0] debounce_ms,
	output qenc_state_t nxt,
	output logic [31:0] value
);

	logic        pressed_now;
	logic        step;
	logic        up;
	logic [31:0] ct_new;
	logic [31:0] elapsed;
	qenc_state_t smp;

	assign pressed_now = ~item.button_level;

	// decoder: phase a change wins over phase b change
	always_comb begin
		step = 1'b0;
		up = 1'b0;
		if (item.phase_a != cur.prev_phase_a) begin
			step = 1'b1;
			up = (item.phase_b == cur.prev_phase_a);
		end else if (item.phase_b != cur.prev_phase_b) begin
			step = 1'b1;
			up = (item.phase_a != cur.prev_phase_b);
		end
	end

	assign ct_new = (pressed_now != cur.prev_button) ? item.now_ms : cur.change_time;
	assign elapsed = item.now_ms - ct_new;

	// sample update
	always_comb begin
		smp = cur;
		if (step) begin
			smp.prev_phase_a = item.phase_a;
			smp.prev_phase_b = item.phase_b;
			if (up) begin
				smp.position_count = cur.position_count + 32'd1;
				smp.last_direction = DIR_UP;
			end else begin
				smp.position_count = cur.position_count - 32'd1;
				smp.last_direction = DIR_DOWN;
			end
		end
		smp.change_time = ct_new;
		smp.prev_button = pressed_now;
		if (elapsed > {16'd0, debounce_ms}) begin
			if (pressed_now && !cur.pressed_flag) begin
				smp.pressed_flag = 1'b1;
				smp.press_edge = 1'b1;
				smp.press_total = cur.press_total + 8'd1;
			end else if (!pressed_now && cur.pressed_flag) begin
				smp.pressed_flag = 1'b0;
			end
		end
	end

	always_comb begin
		nxt = cur;
		value = '0;
		case (item.func)
			FN_SAMPLE: begin
				nxt = smp;
			end
			FN_INIT: begin
				nxt.prev_phase_a = item.phase_a;
				nxt.prev_phase_b = item.phase_b;
				nxt.prev_button = pressed_now;
			end
			FN_DELTA_CLR: begin
				value = {{30{cur.last_direction[1]}}, cur.last_direction};
				nxt.last_direction = DIR_NONE;
			end
			FN_POSITION: begin
				value = cur.position_count;
			end
			FN_ZERO_POS: begin
				nxt.position_count = '0;
			end
			FN_EDGE_CLR: begin
				value = {31'd0, cur.press_edge};
				nxt.press_edge = 1'b0;
			end
			FN_PRESSED: begin
				value = {31'd0, cur.pressed_flag};
			end
			default: begin
				value = {24'd0, cur.press_total};
				nxt.press_total = '0;
			end
		endcase
	end

endmodule

FILE: tb/quadrature_encoder_with_button_core_tb.sv
// testbench for the quadrature encoder bank: directed table, random sequences, predictor check
module quadrature_encoder_with_button_core_tb;
	import qenc_pkg::*;

	localparam int ENC = QENC_ENCODERS;
	localparam qenc_out_t NO_RES = '0;

	// one row of the directed table: the item, and a typed result where it is obvious
	typedef struct packed {
		qenc_in_t  itm;
		logic      typed;
		qenc_out_t res;
	} stim_row_t;

	// directed rows: reset values, invalid encoders, both step directions, position wrap,
	// zero position, delta clear, debounce boundary (elapsed equal is not enough),
	// press and release, edge clear, count clear and a debounce window across the time wrap
	localparam stim_row_t DIRECTED [27] = '{
		'{'{FN_POSITION,  2'd0, 1'b0, 1'b0, 1'b1, 32'd0},          1'b1, '{32'sd0, 1'b1}},
		'{'{FN_DELTA_CLR, 2'd1, 1'b0, 1'b0, 1'b1, 32'd0},          1'b1, '{32'sd0, 1'b1}},
		'{'{FN_PRESSED,   2'd2, 1'b0, 1'b0, 1'b1, 32'd0},          1'b1, '{32'sd0, 1'b0}},
		'{'{FN_SAMPLE,    2'd3, 1'b1, 1'b1, 1'b0, 32'hFFFF_FFFF},  1'b1, '{32'sd0, 1'b0}},
		'{'{FN_INIT,      2'd0, 1'b0, 1'b0, 1'b1, 32'd0},          1'b0, NO_RES},
		'{'{FN_SAMPLE,    2'd0, 1'b1, 1'b0, 1'b1, 32'd10},         1'b0, NO_RES},
		'{'{FN_SAMPLE,    2'd0, 1'b1, 1'b1, 1'b1, 32'd20},         1'b0, NO_RES},
		'{'{FN_SAMPLE,    2'd0, 1'b0, 1'b1, 1'b1, 32'd30},         1'b0, NO_RES},
		'{'{FN_POSITION,  2'd0, 1'b0, 1'b1, 1'b1, 32'd30},         1'b0, NO_RES},
		'{'{FN_DELTA_CLR, 2'd0, 1'b0, 1'b1, 1'b1, 32'd30},         1'b0, NO_RES},
		'{'{FN_SAMPLE,    2'd0, 1'b1, 1'b1, 1'b1, 32'd40},         1'b0, NO_RES},
		'{'{FN_ZERO_POS,  2'd0, 1'b1, 1'b1, 1'b1, 32'd40},         1'b0, NO_RES},
		'{'{FN_SAMPLE,    2'd0, 1'b1, 1'b0, 1'b1, 32'd50},         1'b0, NO_RES},
		'{'{FN_POSITION,  2'd0, 1'b1, 1'b0, 1'b1, 32'd50},         1'b0, NO_RES},
		'{'{FN_DELTA_CLR, 2'd0, 1'b1, 1'b0, 1'b1, 32'd50},         1'b0, NO_RES},
		'{'{FN_SAMPLE,    2'd0, 1'b1, 1'b0, 1'b0, 32'd100},        1'b0, NO_RES},
		'{'{FN_SAMPLE,    2'd0, 1'b1, 1'b0, 1'b0, 32'd150},        1'b0, NO_RES},
		'{'{FN_PRESSED,   2'd0, 1'b1, 1'b0, 1'b0, 32'd150},        1'b0, NO_RES},
		'{'{FN_SAMPLE,    2'd0, 1'b1, 1'b0, 1'b0, 32'd151},        1'b0, NO_RES},
		'{'{FN_EDGE_CLR,  2'd0, 1'b1, 1'b0, 1'b0, 32'd151},        1'b0, NO_RES},
		'{'{FN_PRESSED,   2'd0, 1'b1, 1'b0, 1'b0, 32'd151},        1'b0, NO_RES},
		'{'{FN_SAMPLE,    2'd0, 1'b1, 1'b0, 1'b1, 32'd300},        1'b0, NO_RES},
		'{'{FN_SAMPLE,    2'd0, 1'b1, 1'b0, 1'b1, 32'd351},        1'b0, NO_RES},
		'{'{FN_SAMPLE,    2'd1, 1'b1, 1'b1, 1'b0, 32'hFFFF_FFF0},  1'b0, NO_RES},
		'{'{FN_SAMPLE,    2'd1, 1'b1, 1'b1, 1'b0, 32'h0000_0030},  1'b0, NO_RES},
		'{'{FN_COUNT_CLR, 2'd1, 1'b1, 1'b1, 1'b0, 32'h0000_0030},  1'b0, NO_RES},
		'{'{FN_COUNT_CLR, 2'd0, 1'b1, 1'b0, 1'b1, 32'd351},        1'b0, NO_RES}
	};

	logic      clk;
	logic      arst_n;
	logic      cfg_we;
	logic [15:0] cfg_wdata;
	logic      in_valid;
	logic      in_stall;
	qenc_in_t  in_item;
	logic      out_valid;
	logic      out_stall;
	qenc_out_t out_item;

	// predicted encoder state, one entry per encoder
	logic [31:0] pos_cnt  [ENC];
	logic [1:0]  dir_last [ENC];
	logic        prv_a    [ENC];
	logic        prv_b    [ENC];
	logic        prv_btn  [ENC];
	logic        prs_flag [ENC];
	logic        prs_edge [ENC];
	logic [7:0]  prs_total[ENC];
	logic [31:0] chg_time [ENC];
	logic [15:0] deb_ms;

	// stimulus generator view of each encoder's pins, invalid numbers included
	logic        gen_a  [4];
	logic        gen_b  [4];
	logic        gen_btn[4];
	logic [31:0] gen_now[4];

	qenc_out_t results_due[$];
	qenc_out_t due_res;
	int        snd_pct;
	int        rcv_pct;
	int        mismatches;
	int        n_items;
	int        n_results;
	int        n_presses;

	quadrature_encoder_with_button_core #(
		.ENCODERS(QENC_ENCODERS)
	) i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.in_item  (in_item),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_item (out_item)
	);

	always #5 clk = ~clk;

	// works out the result of one item and advances the predicted encoder state
	function automatic qenc_out_t decode_item(input qenc_in_t it);
		qenc_out_t res;
		int        e;
		logic      pressed_now;
		logic      step;
		logic      up;
		res = '0;
		e = int'(it.encoder_id);
		pressed_now = ~it.button_level;
		step = 1'b0;
		up = 1'b0;
		// out-of-range encoder: zero result, nothing touched
		if (e >= ENC) return res;
		res.id_valid = 1'b1;
		case (it.func)
			FN_SAMPLE: begin
				// phase A has priority over phase B
				if (it.phase_a != prv_a[e]) begin
					step = 1'b1;
					up = (it.phase_b == prv_a[e]);
				end else if (it.phase_b != prv_b[e]) begin
					step = 1'b1;
					up = (it.phase_a != prv_b[e]);
				end
				if (step) begin
					pos_cnt[e] = up ? pos_cnt[e] + 32'd1 : pos_cnt[e] - 32'd1;
					dir_last[e] = up ? DIR_UP : DIR_DOWN;
					prv_a[e] = it.phase_a;
					prv_b[e] = it.phase_b;
				end
				if (pressed_now != prv_btn[e]) begin
					chg_time[e] = it.now_ms;
					prv_btn[e] = pressed_now;
				end
				// elapsed time wraps; must strictly exceed the debounce time
				if (it.now_ms - chg_time[e] > {16'd0, deb_ms}) begin
					if (pressed_now && !prs_flag[e]) begin
						prs_flag[e] = 1'b1;
						prs_edge[e] = 1'b1;
						prs_total[e] = prs_total[e] + 8'd1;
						n_presses++;
					end else if (!pressed_now && prs_flag[e]) begin
						prs_flag[e] = 1'b0;
					end
				end
			end
			FN_INIT: begin
				prv_a[e] = it.phase_a;
				prv_b[e] = it.phase_b;
				prv_btn[e] = pressed_now;
			end
			FN_DELTA_CLR: begin
				res.read_value = {{30{dir_last[e][1]}}, dir_last[e]};
				dir_last[e] = DIR_NONE;
			end
			FN_POSITION: res.read_value = pos_cnt[e];
			FN_ZERO_POS: pos_cnt[e] = '0;
			FN_EDGE_CLR: begin
				res.read_value = {31'd0, prs_edge[e]};
				prs_edge[e] = 1'b0;
			end
			FN_PRESSED: res.read_value = {31'd0, prs_flag[e]};
			default: begin
				res.read_value = {24'd0, prs_total[e]};
				prs_total[e] = '0;
			end
		endcase
		return res;
	endfunction

	// offers one item after a random gap and records its expected result on acceptance
	task automatic send_item(input qenc_in_t it, input logic typed, input qenc_out_t typed_res);
		qenc_out_t res;
		while ($urandom_range(0, 99) < snd_pct) begin
			@(negedge clk);
			in_valid <= 1'b0;
		end
		@(negedge clk);
		in_valid <= 1'b1;
		in_item <= it;
		do @(posedge clk); while (in_stall);
		res = decode_item(it);
		results_due.push_back(typed ? typed_res : res);
		n_items++;
	endtask

	// drops valid and waits for every outstanding result
	task automatic wait_drained();
		@(negedge clk);
		in_valid <= 1'b0;
		while (results_due.size() != 0) @(posedge clk);
	endtask

	// debounce writes only happen with the bank idle
	task automatic set_debounce(input logic [15:0] value);
		wait_drained();
		repeat (4) @(posedge clk);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= value;
		@(negedge clk);
		cfg_we <= 1'b0;
		deb_ms = value;
	endtask

	// random part: mostly clean gray-code rotation and held button levels with
	// rising time, plus some fully random items as noise
	task automatic run_phase(input int count, input int pause_at);
		qenc_in_t   it;
		int         e;
		int         r;
		logic [2:0] fn;
		logic [1:0] ab;
		for (int k = 0; k < count; k++) begin
			// hold off once until the bank has drained completely
			if (k == pause_at) wait_drained();
			r = $urandom_range(0, 9);
			e = (r < 4) ? 0 : (r < 8) ? 1 : (r == 8) ? 2 : 3;
			if ($urandom_range(0, 9) == 0) begin
				it.func = 3'($urandom_range(0, 7));
				it.encoder_id = 2'($urandom_range(0, 3));
				it.phase_a = 1'($urandom_range(0, 1));
				it.phase_b = 1'($urandom_range(0, 1));
				it.button_level = 1'($urandom_range(0, 1));
				it.now_ms = $urandom;
			end else begin
				r = $urandom_range(0, 99);
				fn = (r < 55) ? FN_SAMPLE : (r < 60) ? FN_INIT : (r < 67) ? FN_DELTA_CLR :
					(r < 74) ? FN_POSITION : (r < 78) ? FN_ZERO_POS : (r < 85) ? FN_EDGE_CLR :
					(r < 92) ? FN_PRESSED : FN_COUNT_CLR;
				if (fn == FN_SAMPLE) begin
					ab = {gen_a[e], gen_b[e]};
					r = $urandom_range(0, 99);
					if (r < 45) begin
						// one step forward: 00 10 11 01
						case (ab)
							2'b00: ab = 2'b10;
							2'b10: ab = 2'b11;
							2'b11: ab = 2'b01;
							default: ab = 2'b00;
						endcase
					end else if (r < 85) begin
						case (ab)
							2'b00: ab = 2'b01;
							2'b01: ab = 2'b11;
							2'b11: ab = 2'b10;
							default: ab = 2'b00;
						endcase
					end else if (r >= 95) begin
						// skipped step or glitch
						ab = 2'($urandom_range(0, 3));
					end
					gen_a[e] = ab[1];
					gen_b[e] = ab[0];
					if ($urandom_range(0, 99) < 15) gen_btn[e] = ~gen_btn[e];
					r = $urandom_range(0, 99);
					// time steps scale with the debounce time so that levels get accepted
					if (r < 4)
						gen_now[e] = $urandom;
					else if (r < 30)
						gen_now[e] += 32'($urandom_range(0, int'(deb_ms) + int'(deb_ms) / 2 + 2));
					else
						gen_now[e] += 32'($urandom_range(0, int'(deb_ms) / 8 + 2));
				end else if (fn == FN_INIT && $urandom_range(0, 4) == 0) begin
					gen_a[e] = 1'($urandom_range(0, 1));
					gen_b[e] = 1'($urandom_range(0, 1));
					gen_btn[e] = 1'($urandom_range(0, 1));
				end
				it.func = fn;
				it.encoder_id = 2'(e);
				it.phase_a = gen_a[e];
				it.phase_b = gen_b[e];
				it.button_level = gen_btn[e];
				it.now_ms = gen_now[e];
			end
			send_item(it, 1'b0, NO_RES);
		end
	endtask

	// result side: random stall, refreshed at every falling edge
	always @(negedge clk) begin
		out_stall <= ($urandom_range(0, 99) < rcv_pct);
	end

	// compare each accepted result with the oldest expectation
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			if (results_due.size() == 0) begin
				mismatches++;
				$display("%0t: unexpected result item: read_value %0d id_valid %0b",
					$time, out_item.read_value, out_item.id_valid);
			end else begin
				due_res = results_due.pop_front();
				n_results++;
				if (due_res.read_value !== out_item.read_value) begin
					mismatches++;
					$display("%0t: read_value mismatch: expected %0d (%h) got %0d (%h)", $time,
						due_res.read_value, due_res.read_value, out_item.read_value,
						out_item.read_value);
				end
				if (due_res.id_valid !== out_item.id_valid) begin
					mismatches++;
					$display("%0t: id_valid mismatch: expected %0b got %0b",
						$time, due_res.id_valid, out_item.id_valid);
				end
			end
		end
	end

	// main sequence
	initial begin
		logic [15:0] last_deb;
		clk = 1'b0;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = '0;
		in_valid = 1'b0;
		in_item = '0;
		out_stall = 1'b0;
		snd_pct = 0;
		rcv_pct = 0;
		mismatches = 0;
		n_items = 0;
		n_results = 0;
		n_presses = 0;
		deb_ms = QENC_DEBOUNCE_RST;
		for (int i = 0; i < ENC; i++) begin
			pos_cnt[i] = '0;
			dir_last[i] = DIR_NONE;
			prv_a[i] = 1'b0;
			prv_b[i] = 1'b0;
			prv_btn[i] = 1'b0;
			prs_flag[i] = 1'b0;
			prs_edge[i] = 1'b0;
			prs_total[i] = '0;
			chg_time[i] = '0;
		end
		for (int i = 0; i < 4; i++) begin
			gen_a[i] = 1'b0;
			gen_b[i] = 1'b0;
			gen_btn[i] = 1'b1;
			gen_now[i] = 32'd1000;
		end
		// reset asserted, then released on a falling edge
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// sender idles 31 percent, receiver stalls 69 percent
		snd_pct = 31;
		rcv_pct = 69;
		for (int i = 0; i < $size(DIRECTED); i++)
			send_item(DIRECTED[i].itm, DIRECTED[i].typed, DIRECTED[i].res);
		// random at the reset debounce time
		run_phase(285, -1);

		// shortest debounce, idling swapped, one full drain halfway through
		set_debounce(16'd0);
		snd_pct = 69;
		rcv_pct = 31;
		run_phase(285, 140);

		// longest debounce, no idling from here on
		set_debounce(16'hFFFF);
		snd_pct = 0;
		rcv_pct = 0;
		run_phase(285, -1);

		last_deb = 16'($urandom_range(1, 400));
		set_debounce(last_deb);
		run_phase(285, -1);

		// let the pipeline empty out, then keep waiting for stray results
		wait_drained();
		repeat (8) @(posedge clk);
		$display("summary: %0d items sent, %0d results checked, %0d debounced presses predicted",
			n_items, n_results, n_presses);
		$display("summary: debounce 50, 0, 65535 and %0d ms; idle mixes 31/69, 69/31 and none",
			last_deb);
		if (mismatches == 0) begin
			$display("quadrature_encoder_with_button_core_tb passed");
		end else begin
			$display("quadrature_encoder_with_button_core_tb failed");
		end
		$finish;
	end

	// watchdog: far beyond the slowest legal run
	initial begin
		#5_000_000;
		$display("%0t: timeout with %0d results outstanding", $time, results_due.size());
		$display("quadrature_encoder_with_button_core_tb failed");
		$finish;
	end

endmodule
